/* hdl/vps_pkg.sv */
// Shared types and constants for the vibration pattern sequencer.
package vps_pkg;

  localparam int TICK_W   = 16;  // phase length counter width
  localparam int REPEAT_W = 10;  // repeat count field width
  localparam int PHASE_W  = 12;  // phase counters, up to 4 x repeat count
  localparam int CFG_AW   = 3;   // config register index width

  localparam logic [REPEAT_W-1:0] REPEAT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_FAST = 2'd1,
    OP_SLOW = 2'd2,
    OP_STOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FAST = 2'd1,
    MODE_SLOW = 2'd2
  } mode_t;

  // config register indexes
  localparam logic [CFG_AW-1:0] REG_FAST_ON        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FAST_SHORT_GAP = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FAST_LONG_GAP  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SLOW_ON        = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SLOW_GAP       = 3'd4;

  // config reset values
  localparam logic [TICK_W-1:0] FAST_ON_RST        = 16'd300;
  localparam logic [TICK_W-1:0] FAST_SHORT_GAP_RST = 16'd200;
  localparam logic [TICK_W-1:0] FAST_LONG_GAP_RST  = 16'd1200;
  localparam logic [TICK_W-1:0] SLOW_ON_RST        = 16'd300;
  localparam logic [TICK_W-1:0] SLOW_GAP_RST       = 16'd1700;

endpackage

/* hdl/vibration_pattern_sequencer_unit.sv */
// Vibration pattern sequencer: timed on/off motor patterns driven by tick words.
//
// Each input word is a command: tick, start fast, start slow or stop. A start
// aborts any running pattern, turns the motor on and loads the first on phase;
// fast runs repeat_count cycles of on / short gap / on / long gap, slow runs
// repeat_count cycles of on / gap. Each tick counts the current phase down and
// moves to the next phase when it reaches zero, going idle with the motor off
// after the last one (a repeat count of zero still gives one on phase). Phase
// lengths come from five 16-bit config registers, sampled when a phase loads;
// a length of zero counts as one tick. Exactly one output word (motor level,
// busy) comes out per input word. Throughput is one word per clock: the
// whole state update is a single decrement, compare and phase select done on
// the accepting edge, and the result sits in one output register, so a new
// word is taken whenever that register is empty or being drained. A valid
// output word appears in the cycle after acceptance. Config writes are taken
// at any time but should only be issued while no pattern is running.
module vibration_pattern_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [9:0] repeat_count
  input  logic [1:0]                    s_axis_tuser,  // [1:0] operation
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [0] motor_on, [1] busy_res
  // config write port
  input  logic                          cfg_we,
  input  logic [vps_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [vps_pkg::TICK_W-1:0]    cfg_data
);
  import vps_pkg::*;

  // config registers
  logic [TICK_W-1:0] fast_on_ticks;
  logic [TICK_W-1:0] fast_short_gap_ticks;
  logic [TICK_W-1:0] fast_long_gap_ticks;
  logic [TICK_W-1:0] slow_on_ticks;
  logic [TICK_W-1:0] slow_gap_ticks;

  // pattern state
  mode_t              pattern_mode, pattern_mode_next;
  logic [PHASE_W-1:0] phases_done, phases_done_next;
  logic [PHASE_W-1:0] phases_total, phases_total_next;
  logic [TICK_W-1:0]  ticks_left, ticks_left_next;
  logic               drive_level, drive_level_next;

  // output register
  logic               out_valid;
  logic               out_motor;
  logic               out_busy;

  logic               in_fire;
  op_t                op;
  logic [REPEAT_W-1:0] rep_sat;
  logic [TICK_W-1:0]  ticks_dec;

  // phase loader outputs
  mode_t              load_mode;
  logic [1:0]         load_idx;
  logic [TICK_W-1:0]  load_len;
  logic               load_level;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_busy, out_motor};

  // zero length runs as one tick
  function automatic logic [TICK_W-1:0] phase_len(input logic [TICK_W-1:0] v);
    phase_len = (v == '0) ? TICK_W'(1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_on_ticks        <= FAST_ON_RST;
      fast_short_gap_ticks <= FAST_SHORT_GAP_RST;
      fast_long_gap_ticks  <= FAST_LONG_GAP_RST;
      slow_on_ticks        <= SLOW_ON_RST;
      slow_gap_ticks       <= SLOW_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FAST_ON:        fast_on_ticks        <= cfg_data;
        REG_FAST_SHORT_GAP: fast_short_gap_ticks <= cfg_data;
        REG_FAST_LONG_GAP:  fast_long_gap_ticks  <= cfg_data;
        REG_SLOW_ON:        slow_on_ticks        <= cfg_data;
        REG_SLOW_GAP:       slow_gap_ticks       <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // repeat field already fits 10 bits; clamp kept for the stated limit
  assign rep_sat = (s_axis_tdata[REPEAT_W-1:0] > REPEAT_MAX) ?
                   REPEAT_MAX : s_axis_tdata[REPEAT_W-1:0];

  assign ticks_dec = (ticks_left != '0) ? ticks_left - TICK_W'(1) : '0;

  // a start loads phase 0 of the new pattern, a tick the next phase of the running one
  assign load_mode = (op == OP_FAST) ? MODE_FAST :
                     (op == OP_SLOW) ? MODE_SLOW : pattern_mode;
  assign load_idx  = (op == OP_FAST || op == OP_SLOW) ? 2'd0 : phases_done[1:0];

  // phase loader: length and motor level of phase load_idx in load_mode
  always_comb begin
    load_len   = phase_len(slow_on_ticks);
    load_level = 1'b1;
    if (load_mode == MODE_FAST) begin
      case (load_idx)
        2'd0, 2'd2: begin
          load_len   = phase_len(fast_on_ticks);
          load_level = 1'b1;
        end
        2'd1: begin
          load_len   = phase_len(fast_short_gap_ticks);
          load_level = 1'b0;
        end
        default: begin
          load_len   = phase_len(fast_long_gap_ticks);
          load_level = 1'b0;
        end
      endcase
    end else if (load_idx[0]) begin
      load_len   = phase_len(slow_gap_ticks);
      load_level = 1'b0;
    end
  end

  // next state
  always_comb begin
    pattern_mode_next = pattern_mode;
    phases_done_next  = phases_done;
    phases_total_next = phases_total;
    ticks_left_next   = ticks_left;
    drive_level_next  = drive_level;

    unique case (op)
      OP_FAST, OP_SLOW: begin
        pattern_mode_next = load_mode;
        // total = repeat x 4 or repeat x 2
        phases_total_next = (op == OP_FAST) ? {rep_sat, 2'b00}
                                            : {1'b0, rep_sat, 1'b0};
        phases_done_next  = PHASE_W'(1);
        ticks_left_next   = load_len;
        drive_level_next  = load_level;
      end
      OP_STOP: begin
        pattern_mode_next = MODE_IDLE;
        phases_done_next  = '0;
        phases_total_next = '0;
        ticks_left_next   = '0;
        drive_level_next  = 1'b0;
      end
      default: begin  // tick
        if (pattern_mode != MODE_IDLE) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            if (phases_done >= phases_total) begin
              pattern_mode_next = MODE_IDLE;
              phases_done_next  = '0;
              phases_total_next = '0;
              ticks_left_next   = '0;
              drive_level_next  = 1'b0;
            end else begin
              ticks_left_next  = load_len;
              drive_level_next = load_level;
              phases_done_next = phases_done + PHASE_W'(1);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_IDLE;
      phases_done  <= '0;
      phases_total <= '0;
      ticks_left   <= '0;
      drive_level  <= 1'b0;
    end else if (in_fire) begin
      pattern_mode <= pattern_mode_next;
      phases_done  <= phases_done_next;
      phases_total <= phases_total_next;
      ticks_left   <= ticks_left_next;
      drive_level  <= drive_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_motor <= drive_level_next;
      out_busy  <= (pattern_mode_next != MODE_IDLE);
    end
  end

  // motor never runs without a pattern
  a_motor_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_motor |-> out_busy)
    else $error("motor on while idle");

  // idle leaves counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    pattern_mode == MODE_IDLE |-> ticks_left == '0 && !drive_level)
    else $error("idle with live phase state");

  // running phase always has ticks left
  a_run_ticks: assert property (@(posedge clk) disable iff (rst)
    pattern_mode != MODE_IDLE |-> ticks_left != '0)
    else $error("running phase with zero length");

  // a start leaves the motor on and the pattern running
  a_start_on: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_FAST || op == OP_SLOW)
      |=> drive_level && pattern_mode != MODE_IDLE && phases_done == PHASE_W'(1))
    else $error("start did not load first on phase");

endmodule
